FILE: design/pfq_pkg.sv
// ----------------------------------------------------------------------------
// pfq_pkg: shared types and codes for the priority ready queue
// Field widths, status codes and the link and command structs that pass
// between the queue cells and the top level.
// ----------------------------------------------------------------------------
package pfq_pkg;

  localparam int PID_W  = 8;
  localparam int PRIO_W = 3;
  localparam int ST_W   = 2;

  localparam logic       REQ_PUSH = 1'b0;
  localparam logic       REQ_POP  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              vld;
    logic              gt;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
  } pfq_link_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
  } pfq_cmd_t;

endpackage

FILE: design/priority_fifo_ready_queue_top.sv
// ----------------------------------------------------------------------------
// priority_fifo_ready_queue_top: priority ready queue, FIFO within a level
// A row of cells kept in order of priority, then age. Push inserts behind
// all entries of equal or better priority; pop removes the head cell.
//
//   Channel  | Handshake      | Ports
//   ---------+----------------+-------------------------------------
//   request  | start & !busy  | in_req_type, in_pid, in_prio
//   result   | out_valid      | out_popped_pid, out_status
//
// A request is taken when start is high and busy is low; its result shows
// in the next cycle for a single cycle, during which busy is high, so no
// request is taken while a result shows. Reset empties the queue at once.
// The receiver cannot stall; a result is never held back.
// ----------------------------------------------------------------------------
module priority_fifo_ready_queue_top
  import pfq_pkg::*;
#(
  parameter int CAPACITY        = 16,
  parameter int LOWEST_PRIORITY = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [PID_W-1:0]  in_pid,
  input  logic [PRIO_W-1:0] in_prio,
  output logic              out_valid,
  output logic [PID_W-1:0]  out_popped_pid,
  output logic [ST_W-1:0]   out_status
);

  localparam int CMP_W = PRIO_W + 2;

  pfq_link_t         link [CAPACITY];
  pfq_link_t         head_link;
  pfq_link_t         tail_link;
  pfq_cmd_t          cmd;
  logic              accept;
  logic              full;
  logic              empty;
  logic [PRIO_W-1:0] prio_sat;

  logic              busy_r, busy_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;

  assign accept = start && !busy_r;
  assign full   = link[CAPACITY-1].vld;
  assign empty  = !link[0].vld;

  assign prio_sat = ({2'b00, in_prio} > CMP_W'(LOWEST_PRIORITY)) ?
                    PRIO_W'(LOWEST_PRIORITY) : in_prio;

  assign cmd = '{push: accept && (in_req_type == REQ_PUSH) && !full,
                 pop:  accept && (in_req_type == REQ_POP) && !empty,
                 pid:  in_pid,
                 prio: prio_sat};

  assign head_link = '{vld: 1'b1, gt: 1'b0, pid: '0, prio: '0};
  assign tail_link = '{vld: 1'b0, gt: 1'b0, pid: '0, prio: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pfq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .left_in  ((i == 0) ? head_link : link[(i == 0) ? 0 : i-1]),
      .right_in ((i == CAPACITY-1) ? tail_link : link[(i == CAPACITY-1) ? i : i+1]),
      .link_out (link[i])
    );
  end

  always_comb begin
    busy_nxt = accept;
    pid_nxt  = '0;
    st_nxt   = ST_OK;
    if (accept) begin
      if (in_req_type == REQ_PUSH) begin
        if (full) begin
          st_nxt = ST_FULL;
        end
      end else if (empty) begin
        st_nxt = ST_EMPTY;
      end else begin
        pid_nxt = link[0].pid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    pid_r <= pid_nxt;
    st_r  <= st_nxt;
  end

  assign busy           = busy_r;
  assign out_valid      = busy_r;
  assign out_popped_pid = pid_r;
  assign out_status     = st_r;

endmodule

FILE: design/pfq_cell.sv
// ----------------------------------------------------------------------------
// pfq_cell: one slot of the sorted ready queue
// Holds one entry. On push, shifts right when its neighbor shifts or takes
// the new entry at the first slot ranked after it; on pop, takes the entry
// from its right neighbor.
// ----------------------------------------------------------------------------
module pfq_cell
  import pfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pfq_cmd_t  cmd,
  input  pfq_link_t left_in,
  input  pfq_link_t right_in,
  output pfq_link_t link_out
);

  logic              vld_r, vld_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              gt;

  assign gt = vld_r && (prio_r > cmd.prio);

  always_comb begin
    vld_nxt  = vld_r;
    pid_nxt  = pid_r;
    prio_nxt = prio_r;
    if (cmd.push) begin
      if (left_in.gt) begin
        vld_nxt  = 1'b1;
        pid_nxt  = left_in.pid;
        prio_nxt = left_in.prio;
      end else if (left_in.vld && (gt || !vld_r)) begin
        vld_nxt  = 1'b1;
        pid_nxt  = cmd.pid;
        prio_nxt = cmd.prio;
      end
    end else if (cmd.pop) begin
      vld_nxt  = right_in.vld;
      pid_nxt  = right_in.pid;
      prio_nxt = right_in.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    pid_r  <= pid_nxt;
    prio_r <= prio_nxt;
  end

  assign link_out = '{vld: vld_r, gt: gt, pid: pid_r, prio: prio_r};

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the priority ready queue
// Walks a table of directed requests (empty pops, saturated priorities, a
// single-entry pop, fill to full and drain), then random push/pop traffic
// whose push share varies from block to block so the queue sweeps between
// empty and full. Each result is checked against the table entry or an in-bench queue model.
// ----------------------------------------------------------------------------
module testbench;
  import pfq_pkg::*;

  localparam int              CAPACITY      = 16;
  localparam logic [PRIO_W-1:0] LOWEST_PRIO = 3'd4;
  localparam int              RAND_BLOCKS   = 31;
  localparam int              BLOCK_ITEMS   = 50;
  localparam int              STALL_LIMIT   = 1000;
  localparam int              DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic              req;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic [5:0]        count;
    logic              typed;
    logic [PID_W-1:0]  exp_pid;
    logic [ST_W-1:0]   exp_st;
  } stim_row_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [ST_W-1:0]  status;
  } pop_result_t;

  localparam int N_ROWS = 18;
  localparam stim_row_t DIRECTED [0:N_ROWS-1] = '{
    '{REQ_POP,  8'h00, 3'd0,  6'd1, 1'b1, 8'h00, ST_EMPTY},
    '{REQ_PUSH, 8'hFF, 3'd0,  6'd1, 1'b1, 8'h00, ST_OK},
    '{REQ_POP,  8'h00, 3'd0,  6'd1, 1'b1, 8'hFF, ST_OK},
    '{REQ_POP,  8'h00, 3'd0,  6'd1, 1'b1, 8'h00, ST_EMPTY},
    '{REQ_PUSH, 8'h00, 3'd7,  6'd1, 1'b1, 8'h00, ST_OK},
    '{REQ_PUSH, 8'h01, 3'd4,  6'd1, 1'b1, 8'h00, ST_OK},
    '{REQ_PUSH, 8'h02, 3'd5,  6'd1, 1'b1, 8'h00, ST_OK},
    '{REQ_PUSH, 8'h03, 3'd0,  6'd1, 1'b1, 8'h00, ST_OK},
    '{REQ_PUSH, 8'h04, 3'd0,  6'd1, 1'b0, 8'h00, ST_OK},
    '{REQ_POP,  8'hFF, 3'd7,  6'd1, 1'b0, 8'h00, ST_OK},
    '{REQ_POP,  8'h00, 3'd0,  6'd1, 1'b0, 8'h00, ST_OK},
    '{REQ_POP,  8'h00, 3'd0,  6'd1, 1'b0, 8'h00, ST_OK},
    '{REQ_POP,  8'h00, 3'd0,  6'd1, 1'b0, 8'h00, ST_OK},
    '{REQ_POP,  8'h00, 3'd0,  6'd1, 1'b0, 8'h00, ST_OK},
    '{REQ_POP,  8'h00, 3'd0,  6'd1, 1'b1, 8'h00, ST_EMPTY},
    '{REQ_PUSH, 8'h10, 3'd0, 6'd16, 1'b1, 8'h00, ST_OK},
    '{REQ_PUSH, 8'hAA, 3'd3,  6'd1, 1'b1, 8'h00, ST_FULL},
    '{REQ_POP,  8'hFF, 3'd0, 6'd17, 1'b0, 8'h00, ST_OK}
  };

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_req_type;
  logic [PID_W-1:0]  in_pid;
  logic [PRIO_W-1:0] in_prio;
  logic              out_valid;
  logic [PID_W-1:0]  out_popped_pid;
  logic [ST_W-1:0]   out_status;

  logic [PID_W-1:0]  mdl_pid  [CAPACITY];
  logic [PRIO_W-1:0] mdl_prio [CAPACITY];
  int                mdl_occ;

  pop_result_t       pending_results [$];
  int                mismatches;
  int                stall_cycles;
  bit                no_idle;

  priority_fifo_ready_queue_top #(
    .CAPACITY       (CAPACITY),
    .LOWEST_PRIORITY(4)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_pid        (in_pid),
    .in_prio       (in_prio),
    .out_valid     (out_valid),
    .out_popped_pid(out_popped_pid),
    .out_status    (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void ready_queue_step(input logic req, input logic [PID_W-1:0] pid,
                                           input logic [PRIO_W-1:0] prio,
                                           output logic [PID_W-1:0] got,
                                           output logic [ST_W-1:0] st);
    int best;
    int i;
    got = '0;
    st  = ST_OK;
    if (req == REQ_PUSH) begin
      if (mdl_occ >= CAPACITY) begin
        st = ST_FULL;
      end else begin
        mdl_pid[mdl_occ]  = pid;
        mdl_prio[mdl_occ] = (prio > LOWEST_PRIO) ? LOWEST_PRIO : prio;
        mdl_occ++;
      end
    end else if (mdl_occ == 0) begin
      st = ST_EMPTY;
    end else begin
      best = 0;
      for (i = 1; i < mdl_occ; i++) begin
        if (mdl_prio[i] < mdl_prio[best]) best = i;
      end
      got = mdl_pid[best];
      for (i = best; i + 1 < mdl_occ; i++) begin
        mdl_pid[i]  = mdl_pid[i+1];
        mdl_prio[i] = mdl_prio[i+1];
      end
      mdl_occ--;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  task automatic issue_request(input logic req, input logic [PID_W-1:0] pid,
                               input logic [PRIO_W-1:0] prio, input logic typed,
                               input logic [PID_W-1:0] typed_pid,
                               input logic [ST_W-1:0] typed_st);
    int               gap;
    logic [PID_W-1:0] calc_pid;
    logic [ST_W-1:0]  calc_st;
    pop_result_t      res;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_pid      <= pid;
    in_prio     <= prio;
    do @(posedge clk); while (busy !== 1'b0);
    ready_queue_step(req, pid, prio, calc_pid, calc_st);
    res.pid    = typed ? typed_pid : calc_pid;
    res.status = typed ? typed_st : calc_st;
    pending_results.push_back(res);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", out_status, -1);
      end else begin
        if (out_popped_pid !== pending_results[0].pid)
          report_mismatch("popped_pid", out_popped_pid, pending_results[0].pid);
        if (out_status !== pending_results[0].status)
          report_mismatch("status", out_status, pending_results[0].status);
        void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int               r;
    int               k;
    int               blk;
    int               n;
    int               push_pct;
    logic             req;
    mismatches   = 0;
    mdl_occ      = 0;
    no_idle      = 1'b0;
    stall_cycles <= 0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_req_type  <= REQ_PUSH;
    in_pid       <= '0;
    in_prio      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < N_ROWS; r++) begin
      for (k = 0; k < DIRECTED[r].count; k++) begin
        issue_request(DIRECTED[r].req, DIRECTED[r].pid + PID_W'(k),
                      DIRECTED[r].prio + PRIO_W'(k), DIRECTED[r].typed,
                      DIRECTED[r].exp_pid, DIRECTED[r].exp_st);
      end
    end

    for (blk = 0; blk < RAND_BLOCKS; blk++) begin
      if (blk == RAND_BLOCKS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        req = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
        issue_request(req, PID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 7)),
                      1'b0, '0, ST_OK);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pfq_pkg.sv
design/pfq_cell.sv
design/priority_fifo_ready_queue_top.sv
bench/testbench.sv
